// ===== sv/cvsd_codec_assert.svh =====
// Assertion macros for the CVSD codec. Each macro expects clk and rst_n in scope.
`ifndef CVSD_CODEC_ASSERT_SVH
`define CVSD_CODEC_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold in the same cycle as its trigger.
`define CVSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define CVSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CVSD_ASSERT(lbl, prop, msg)
`define CVSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/cvsd_pkg.sv =====
package cvsd_pkg;

    // Number of past slope bits that form a run.
    localparam int LOOKBACK = 3;
    localparam int HIST_W   = LOOKBACK;
    localparam int FILL_W   = $clog2(LOOKBACK + 1);

    localparam int STEP_W   = 15;
    localparam int COEF_W   = 16;
    localparam int PCM_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_INC   = 3'd0,
        REG_STEP_MIN   = 3'd1,
        REG_STEP_MAX   = 3'd2,
        REG_SHRINK     = 3'd3,
        REG_LEAK       = 3'd4
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0] RST_STEP_INC = 15'd10;
    localparam logic [STEP_W-1:0] RST_STEP_MIN = 15'd10;
    localparam logic [STEP_W-1:0] RST_STEP_MAX = 15'd1280;
    localparam logic [COEF_W-1:0] RST_SHRINK   = 16'd63570;
    localparam logic [COEF_W-1:0] RST_LEAK     = 16'd65208;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [STEP_W-1:0] step_increment;
        logic [STEP_W-1:0] step_minimum;
        logic [STEP_W-1:0] step_maximum;
        logic [COEF_W-1:0] step_shrink_coef;
        logic [COEF_W-1:0] reference_leak_coef;
    } cfg_t;

endpackage

// ===== sv/cvsd_cfg.sv =====
module cvsd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cvsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvsd_pkg::CFG_DATA_W-1:0] cfg_data,
    output cvsd_pkg::cfg_t                  cfg
);
    import cvsd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken; an unknown index leaves every register alone.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index of a write transfer.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_STEP_INC: cfg_next.step_increment      = cfg_data[STEP_W-1:0];
                REG_STEP_MIN: cfg_next.step_minimum        = cfg_data[STEP_W-1:0];
                REG_STEP_MAX: cfg_next.step_maximum        = cfg_data[STEP_W-1:0];
                REG_SHRINK:   cfg_next.step_shrink_coef    = cfg_data[COEF_W-1:0];
                REG_LEAK:     cfg_next.reference_leak_coef = cfg_data[COEF_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_increment      <= RST_STEP_INC;
            cfg_reg.step_minimum        <= RST_STEP_MIN;
            cfg_reg.step_maximum        <= RST_STEP_MAX;
            cfg_reg.step_shrink_coef    <= RST_SHRINK;
            cfg_reg.reference_leak_coef <= RST_LEAK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/cvsd_mul.sv =====
module cvsd_mul (
    input  logic                          clk,
    input  logic [cvsd_pkg::COEF_W-1:0]   a,
    input  logic [cvsd_pkg::COEF_W-1:0]   b,
    output logic [2*cvsd_pkg::COEF_W-1:0] prod
);
    import cvsd_pkg::*;

    logic [2*COEF_W-1:0] prod_reg;
    logic [2*COEF_W-1:0] prod_next;

    // Shared unsigned 16x16 multiplier with a registered product.
    assign prod_next = {{COEF_W{1'b0}}, a} * {{COEF_W{1'b0}}, b};
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== sv/cvsd_codec.sv =====
// CVSD codec with an encoder channel and a decoder channel sharing one datapath.
// Input channel (in_valid / in_stall): action selects the channel; action 0
// encodes pcm_sample against the encoder level, action 1 decodes code_bit.
// Output channel (out_valid / out_stall): bit_out is the slope bit and
// reconstructed the new level of the channel that was used.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready
// and should be written only while no item is in flight.
// Each item runs through S_MUL_STEP, S_UPDATE, S_MUL_LEAK and S_DONE, and its
// result is loaded from S_DONE. The block takes one item at a time and accepts
// the next one the cycle after the result is loaded. The sequence is set by the
// single multiplier, used once for the step shrink and once for the level leak.
// While the receiver stalls, a loaded result holds and the next item still
// runs; it then waits in the final step until the output register is free.
// Reset clears both channels (history, fill, step and level to zero) and loads
// the default configuration.
`include "cvsd_codec_assert.svh"

module cvsd_codec (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic signed [cvsd_pkg::PCM_W-1:0] pcm_sample,
    input  logic                            code_bit,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            bit_out,
    output logic signed [cvsd_pkg::PCM_W-1:0] reconstructed,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cvsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cvsd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_MUL_STEP = 5'b00010,
        S_UPDATE   = 5'b00100,
        S_MUL_LEAK = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    localparam logic signed [PCM_W:0] LVL_MAX = 17'sd32767;
    localparam logic signed [PCM_W:0] LVL_MIN = -17'sd32768;

    cfg_t cfg;

    state_t state_reg, state_next;

    // Channel state.
    logic [HIST_W-1:0]       enc_hist_reg, enc_hist_next, dec_hist_reg, dec_hist_next;
    logic [FILL_W-1:0]       enc_fill_reg, enc_fill_next, dec_fill_reg, dec_fill_next;
    logic [STEP_W-1:0]       enc_step_reg, enc_step_next, dec_step_reg, dec_step_next;
    logic signed [PCM_W-1:0] enc_level_reg, enc_level_next, dec_level_reg, dec_level_next;

    // Working copy of the selected channel.
    logic                    w_act_reg, w_act_next;
    logic                    w_bit_reg, w_bit_next;
    logic [HIST_W-1:0]       w_hist_reg, w_hist_next;
    logic [FILL_W-1:0]       w_fill_reg, w_fill_next;
    logic [STEP_W-1:0]       w_step_reg, w_step_next;
    logic signed [PCM_W-1:0] w_level_reg, w_level_next;
    logic [PCM_W-1:0]        w_mag_reg, w_mag_next;
    logic                    w_neg_reg, w_neg_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic                    out_bit_reg, out_bit_next;
    logic signed [PCM_W-1:0] out_level_reg, out_level_next;

    // Shared multiplier.
    logic [COEF_W-1:0]       mul_a, mul_b;
    logic [2*COEF_W-1:0]     mul_prod;

    // Combinational helpers.
    logic                    in_bit;
    logic [HIST_W-1:0]       sel_hist;
    logic [FILL_W-1:0]       sel_fill;
    logic [STEP_W-1:0]       sel_step;
    logic signed [PCM_W-1:0] sel_level;
    logic                    run;
    logic [STEP_W:0]         grow_sum;
    logic [STEP_W-1:0]       grow_step, shrink_step, new_step;
    logic signed [PCM_W:0]   lvl_raw, lvl_sat, lvl_abs;
    logic [PCM_W-1:0]        leak_mag;
    logic signed [PCM_W-1:0] leak_level;

    cvsd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The step shrink uses the multiplier first, the level leak second.
    always_comb
    begin
        if (state_reg == S_MUL_STEP)
        begin
            mul_a = {1'b0, w_step_reg};
            mul_b = cfg.step_shrink_coef;
        end
        else
        begin
            mul_a = w_mag_reg;
            mul_b = cfg.reference_leak_coef;
        end
    end

    cvsd_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // Slope bit and the state of the selected channel at acceptance.
    assign in_bit    = action ? code_bit : (pcm_sample > enc_level_reg);
    assign sel_hist  = action ? dec_hist_reg  : enc_hist_reg;
    assign sel_fill  = action ? dec_fill_reg  : enc_fill_reg;
    assign sel_step  = action ? dec_step_reg  : enc_step_reg;
    assign sel_level = action ? dec_level_reg : enc_level_reg;

    // Step adaptation: hold until the history is full, then grow on a run of equal bits, shrink otherwise.
    assign run         = (w_hist_reg == {HIST_W{1'b1}}) || (w_hist_reg == {HIST_W{1'b0}});
    assign grow_sum    = {1'b0, w_step_reg} + {1'b0, cfg.step_increment};
    assign grow_step   = (grow_sum < {1'b0, cfg.step_maximum}) ? grow_sum[STEP_W-1:0]
                                                               : cfg.step_maximum;
    assign shrink_step = (mul_prod[COEF_W+STEP_W-1:COEF_W] > cfg.step_minimum)
                         ? mul_prod[COEF_W+STEP_W-1:COEF_W] : cfg.step_minimum;
    always_comb
    begin
        if (w_fill_reg < FILL_W'(LOOKBACK))
            new_step = w_step_reg;
        else if (run)
            new_step = grow_step;
        else
            new_step = shrink_step;
    end

    // Level move by the new step, with saturation, then its magnitude.
    always_comb
    begin
        if (w_bit_reg)
        begin
            lvl_raw = {w_level_reg[PCM_W-1], w_level_reg} + $signed({2'b00, new_step});
            lvl_sat = (lvl_raw > LVL_MAX) ? LVL_MAX : lvl_raw;
        end
        else
        begin
            lvl_raw = {w_level_reg[PCM_W-1], w_level_reg} - $signed({2'b00, new_step});
            lvl_sat = (lvl_raw < LVL_MIN) ? LVL_MIN : lvl_raw;
        end
        lvl_abs = lvl_sat[PCM_W] ? -lvl_sat : lvl_sat;
    end

    // Leak result, truncated toward zero.
    assign leak_mag   = mul_prod[2*COEF_W-1:COEF_W];
    assign leak_level = w_neg_reg ? -$signed(leak_mag) : $signed(leak_mag);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        enc_hist_next  = enc_hist_reg;
        enc_fill_next  = enc_fill_reg;
        enc_step_next  = enc_step_reg;
        enc_level_next = enc_level_reg;
        dec_hist_next  = dec_hist_reg;
        dec_fill_next  = dec_fill_reg;
        dec_step_next  = dec_step_reg;
        dec_level_next = dec_level_reg;
        w_act_next     = w_act_reg;
        w_bit_next     = w_bit_reg;
        w_hist_next    = w_hist_reg;
        w_fill_next    = w_fill_reg;
        w_step_next    = w_step_reg;
        w_level_next   = w_level_reg;
        w_mag_next     = w_mag_reg;
        w_neg_next     = w_neg_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_level_next = out_level_reg;

        // A result leaves on an output transfer.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    w_act_next   = action;
                    w_bit_next   = in_bit;
                    w_hist_next  = {sel_hist[HIST_W-2:0], in_bit};
                    w_fill_next  = (sel_fill < FILL_W'(LOOKBACK)) ? sel_fill + 1'b1 : sel_fill;
                    w_step_next  = sel_step;
                    w_level_next = sel_level;
                    state_next   = S_MUL_STEP;
                end
            end
            S_MUL_STEP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                w_step_next = new_step;
                w_mag_next  = lvl_abs[PCM_W-1:0];
                w_neg_next  = lvl_sat[PCM_W];
                state_next  = S_MUL_LEAK;
            end
            S_MUL_LEAK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Commit once the output register is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    if (w_act_reg)
                    begin
                        dec_hist_next  = w_hist_reg;
                        dec_fill_next  = w_fill_reg;
                        dec_step_next  = w_step_reg;
                        dec_level_next = leak_level;
                    end
                    else
                    begin
                        enc_hist_next  = w_hist_reg;
                        enc_fill_next  = w_fill_reg;
                        enc_step_next  = w_step_reg;
                        enc_level_next = leak_level;
                    end
                    out_valid_next = 1'b1;
                    out_bit_next   = w_bit_reg;
                    out_level_next = leak_level;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and channel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            enc_hist_reg  <= '0;
            enc_fill_reg  <= '0;
            enc_step_reg  <= '0;
            enc_level_reg <= '0;
            dec_hist_reg  <= '0;
            dec_fill_reg  <= '0;
            dec_step_reg  <= '0;
            dec_level_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            enc_hist_reg  <= enc_hist_next;
            enc_fill_reg  <= enc_fill_next;
            enc_step_reg  <= enc_step_next;
            enc_level_reg <= enc_level_next;
            dec_hist_reg  <= dec_hist_next;
            dec_fill_reg  <= dec_fill_next;
            dec_step_reg  <= dec_step_next;
            dec_level_reg <= dec_level_next;
        end
    end

    // Working and output payload.
    always_ff @(posedge clk)
    begin
        w_act_reg     <= w_act_next;
        w_bit_reg     <= w_bit_next;
        w_hist_reg    <= w_hist_next;
        w_fill_reg    <= w_fill_next;
        w_step_reg    <= w_step_next;
        w_level_reg   <= w_level_next;
        w_mag_reg     <= w_mag_next;
        w_neg_reg     <= w_neg_next;
        out_bit_reg   <= out_bit_next;
        out_level_reg <= out_level_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign bit_out       = out_bit_reg;
    assign reconstructed = out_level_reg;

    // A new result is only loaded from the final step.
    `CVSD_ASSERT(a_load_from_done, !$rose(out_valid_reg) || $past(state_reg == S_DONE), "result loaded outside the final step")
    // An accepted item starts the shrink multiply on the next cycle.
    `CVSD_ASSERT_NEXT(a_accept_starts, (state_reg == S_IDLE) && in_valid, state_reg == S_MUL_STEP, "accepted item did not start")
    // Channel levels only change on a commit.
    `CVSD_ASSERT_NEXT(a_level_commit, state_reg != S_DONE, $stable(enc_level_reg) && $stable(dec_level_reg), "channel level changed without a commit")
    // Fill counts saturate at the history length.
    `CVSD_ASSERT(a_fill_bound, (enc_fill_reg <= FILL_W'(LOOKBACK)) && (dec_fill_reg <= FILL_W'(LOOKBACK)), "fill count beyond history length")

endmodule

// ===== bench/tb_cvsd_codec.sv =====
`timescale 1ns / 100ps

module tb_cvsd_codec;

    import cvsd_pkg::*;

    // Cycles from an input transfer to the matching result, plus the turnaround.
    localparam int PIPE_CYCLES = 5;
    localparam int CFG_SLOTS = 1 << CFG_IDX_W;
    localparam int LEVEL_HI = 32767;
    localparam int LEVEL_LO = -32768;
    localparam logic [PCM_W-1:0] PCM_TOP = 16'h7FFF;
    localparam logic [PCM_W-1:0] PCM_BOTTOM = 16'h8000;
    localparam logic [CFG_DATA_W-1:0] ALL_ONES = 16'hFFFF;
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;
    localparam longint RUN_LIMIT_NS = 3_000_000;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_HOLD} stall_mode_t;

    // One channel of the codec: bit history, fill count, step size and level.
    typedef struct packed {
        logic [HIST_W-1:0] history;
        logic [FILL_W-1:0] fill;
        logic [STEP_W-1:0] step;
        logic [PCM_W-1:0]  level;
    } slope_chan_t;

    typedef struct packed {
        logic             slope_bit;
        logic [PCM_W-1:0] level;
    } codec_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   action = 1'b0;
    logic signed [PCM_W-1:0] pcm_sample = '0;
    logic                   code_bit = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   bit_out;
    logic signed [PCM_W-1:0] reconstructed;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Configuration as the predictor sees it.
    logic [STEP_W-1:0] cur_step_inc = RST_STEP_INC;
    logic [STEP_W-1:0] cur_step_min = RST_STEP_MIN;
    logic [STEP_W-1:0] cur_step_max = RST_STEP_MAX;
    logic [COEF_W-1:0] cur_shrink = RST_SHRINK;
    logic [COEF_W-1:0] cur_leak = RST_LEAK;

    slope_chan_t enc_chan = '0;
    slope_chan_t dec_chan = '0;

    codec_out_t expected_results[$];
    codec_out_t want;
    int outstanding = 0;
    int results_seen = 0;
    int mismatches = 0;
    int burst_left = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int stall_seg_left = 0;

    cvsd_codec u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .pcm_sample   (pcm_sample),
        .code_bit     (code_bit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bit_out      (bit_out),
        .reconstructed(reconstructed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shift one slope bit into a channel and run the step and level update.
    function automatic slope_chan_t advance_channel(slope_chan_t ch, logic b);
        slope_chan_t nxt;
        int unsigned acc;
        int lvl;
        longint mag;
        nxt = ch;
        nxt.history = {ch.history[HIST_W-2:0], b};
        if (ch.fill < LOOKBACK)
            nxt.fill = ch.fill + 1'b1;

        // The step adapts only once the history holds a full window.
        if (nxt.fill >= LOOKBACK)
        begin
            if (nxt.history == '1 || nxt.history == '0)
            begin
                acc = int'(ch.step) + int'(cur_step_inc);
                nxt.step = (acc < cur_step_max) ? acc[STEP_W-1:0] : cur_step_max;
            end
            else
            begin
                acc = int'((longint'(ch.step) * longint'(cur_shrink)) >> 16);
                nxt.step = (acc > cur_step_min) ? acc[STEP_W-1:0] : cur_step_min;
            end
        end

        // Move the level by the step with saturation, then leak toward zero.
        lvl = int'($signed(ch.level));
        if (b)
        begin
            lvl = lvl + int'(nxt.step);
            if (lvl > LEVEL_HI)
                lvl = LEVEL_HI;
        end
        else
        begin
            lvl = lvl - int'(nxt.step);
            if (lvl < LEVEL_LO)
                lvl = LEVEL_LO;
        end
        mag = (lvl < 0) ? -longint'(lvl) : longint'(lvl);
        mag = (mag * longint'(cur_leak)) >> 16;
        lvl = (lvl < 0) ? -int'(mag) : int'(mag);
        nxt.level = lvl[PCM_W-1:0];
        return nxt;
    endfunction

    // Update the channel selected by an accepted transfer and give its result.
    function automatic codec_out_t predict_codec(logic act, logic [PCM_W-1:0] pcm, logic cb);
        codec_out_t res;
        if (act == ACT_DECODE)
        begin
            dec_chan = advance_channel(dec_chan, cb);
            res.slope_bit = cb;
            res.level = dec_chan.level;
        end
        else
        begin
            res.slope_bit = ($signed(pcm) > $signed(enc_chan.level));
            enc_chan = advance_channel(enc_chan, res.slope_bit);
            res.level = enc_chan.level;
        end
        return res;
    endfunction

    task automatic log_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Send one item, idling between bursts, and record what it should produce.
    task automatic push_item(logic act, logic [PCM_W-1:0] pcm, logic cb);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= act;
        pcm_sample <= pcm;
        code_bit <= cb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_codec(act, pcm, cb));
        outstanding++;
    endtask

    // Stop sending and wait until every expected result has been transferred.
    task automatic drain();
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_STEP_INC: cur_step_inc = val[STEP_W-1:0];
            REG_STEP_MIN: cur_step_min = val[STEP_W-1:0];
            REG_STEP_MAX: cur_step_max = val[STEP_W-1:0];
            REG_SHRINK:   cur_shrink = val;
            REG_LEAK:     cur_leak = val;
            default:      ;
        endcase
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(logic [CFG_DATA_W-1:0] inc, logic [CFG_DATA_W-1:0] lo,
                                logic [CFG_DATA_W-1:0] hi, logic [CFG_DATA_W-1:0] shrink,
                                logic [CFG_DATA_W-1:0] leak);
        write_reg(REG_STEP_INC, inc);
        write_reg(REG_STEP_MIN, lo);
        write_reg(REG_STEP_MAX, hi);
        write_reg(REG_SHRINK, shrink);
        write_reg(REG_LEAK, leak);
        end_config();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_step_reg();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'h7FFF;
            2:       return ALL_ONES;
            3, 4:    return CFG_DATA_W'($urandom_range(1, 2000));
            default: return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef_reg();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ALL_ONES;
            2, 3:    return CFG_DATA_W'($urandom_range(60000, 16'hFFFF));
            4:       return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            default: return CFG_DATA_W'($urandom_range(30000, 16'hFFFF));
        endcase
    endfunction

    // The first items after reset leave the step alone until the history fills.
    task automatic test_history_fill();
        drain();
        push_item(ACT_DECODE, '0, 1'b1);
        push_item(ACT_DECODE, PCM_TOP, 1'b1);
        push_item(ACT_DECODE, PCM_BOTTOM, 1'b1);
        push_item(ACT_ENCODE, PCM_TOP, 1'b0);
        push_item(ACT_ENCODE, PCM_BOTTOM, 1'b1);
        push_item(ACT_ENCODE, '0, 1'b0);
        push_item(ACT_ENCODE, ALL_ONES, 1'b1);
        push_item(ACT_DECODE, '0, 1'b0);
    endtask

    // Full growth with the weakest leak drives both levels into their limits.
    task automatic test_level_clamp();
        drain();
        apply_config(16'h7FFF, '0, 16'h7FFF, ALL_ONES, ALL_ONES);
        repeat (4) push_item(ACT_DECODE, PCM_W'($urandom_range(0, 16'hFFFF)), 1'b1);
        repeat (3) push_item(ACT_DECODE, PCM_W'($urandom_range(0, 16'hFFFF)), 1'b0);
        push_item(ACT_ENCODE, PCM_TOP, 1'b0);
        push_item(ACT_ENCODE, PCM_TOP, 1'b1);
        push_item(ACT_ENCODE, PCM_BOTTOM, 1'b0);
    endtask

    // A floor above the ceiling: growth stops at the ceiling, shrink stops at the floor.
    task automatic test_crossed_limits();
        drain();
        apply_config(16'd200, 16'd5000, 16'd300, RST_SHRINK, RST_LEAK);
        push_item(ACT_DECODE, '0, 1'b1);
        push_item(ACT_DECODE, '0, 1'b1);
        push_item(ACT_DECODE, '0, 1'b1);
        push_item(ACT_DECODE, '0, 1'b0);
        push_item(ACT_DECODE, '0, 1'b1);
        push_item(ACT_ENCODE, 16'd1000, 1'b0);
    endtask

    // Writes to indexes past the last register must change nothing.
    task automatic test_unmapped_index();
        int idx;
        drain();
        for (idx = int'(REG_LEAK) + 1; idx < CFG_SLOTS; idx++)
            write_reg(idx[CFG_IDX_W-1:0], (idx[0]) ? ALL_ONES : 16'h0000);
        end_config();
        push_item(ACT_DECODE, '0, 1'b1);
        push_item(ACT_ENCODE, PCM_BOTTOM, 1'b0);
        push_item(ACT_DECODE, '0, 1'b0);
    endtask

    // Mostly runs of decode bits and ramps of PCM samples, with some random noise.
    task automatic run_traffic(int count);
        int n;
        int seg_left;
        int run_left;
        int wave;
        int slope;
        logic seg_action;
        logic run_bit;
        seg_left = 0;
        run_left = 0;
        wave = 0;
        slope = $urandom_range(0, 4000) - 2000;
        seg_action = ACT_ENCODE;
        run_bit = 1'b0;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_item(1'($urandom_range(0, 1)), PCM_W'($urandom_range(0, 16'hFFFF)),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_action = 1'($urandom_range(0, 1));
                    seg_left = $urandom_range(1, 16);
                end
                seg_left--;
                if (seg_action == ACT_DECODE)
                begin
                    if (run_left == 0)
                    begin
                        run_bit = 1'($urandom_range(0, 1));
                        run_left = $urandom_range(1, 6);
                    end
                    run_left--;
                    push_item(ACT_DECODE, PCM_W'($urandom_range(0, 16'hFFFF)), run_bit);
                end
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        slope = $urandom_range(0, 8000) - 4000;
                    wave = wave + slope;
                    if (wave > LEVEL_HI)
                    begin
                        wave = LEVEL_HI;
                        slope = -slope;
                    end
                    else if (wave < LEVEL_LO)
                    begin
                        wave = LEVEL_LO;
                        slope = -slope;
                    end
                    push_item(ACT_ENCODE, wave[PCM_W-1:0], 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // Several configuration phases, the extremes among them.
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 10; phase++)
        begin
            drain();
            case (phase)
                0:       apply_config(CFG_DATA_W'(RST_STEP_INC), CFG_DATA_W'(RST_STEP_MIN),
                                      CFG_DATA_W'(RST_STEP_MAX), RST_SHRINK, RST_LEAK);
                1:       apply_config('0, '0, '0, '0, '0);
                2:       apply_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
                default: apply_config(pick_step_reg(), pick_step_reg(), pick_step_reg(),
                                      pick_coef_reg(), pick_coef_reg());
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_LEAK) + 1, CFG_SLOTS - 1)),
                          CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
                end_config();
            end
            run_traffic(85);
        end
    endtask

    // Receiver stall pattern: segments of random length, each with its own mode.
    always @(posedge clk)
    begin
        if (stall_seg_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_seg_left = $urandom_range(1, 48);
        end
        stall_seg_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= 1'b1;
        endcase
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                log_failure($sformatf("result %0d arrived with nothing expected", results_seen));
            end
            else
            begin
                want = expected_results.pop_front();
                outstanding--;
                if (bit_out !== want.slope_bit)
                    log_failure($sformatf("result %0d bit_out: expected %0b, got %0b",
                                          results_seen, want.slope_bit, bit_out));
                if (reconstructed !== want.level)
                    log_failure($sformatf("result %0d reconstructed: expected %0d, got %0d",
                                          results_seen, $signed(want.level), reconstructed));
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_history_fill();
        test_level_clamp();
        test_crossed_limits();
        test_unmapped_index();
        test_random_traffic();

        drain();
        repeat (PIPE_CYCLES + 2) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/cvsd_pkg.sv
sv/cvsd_cfg.sv
sv/cvsd_mul.sv
sv/cvsd_codec.sv
bench/tb_cvsd_codec.sv
